@@ rtl/sparse_coordinate_accumulator_core_defines.svh @@
// Assertion macros for the coordinate accumulator core.
`ifndef SPARSE_COORDINATE_ACCUMULATOR_CORE_DEFINES_SVH
`define SPARSE_COORDINATE_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define SCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sca assertion failed");
`define SCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sca assertion failed");
`else
`define SCA_ASSERT_IMP(lbl, ante, cons)
`define SCA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/sca_pkg.sv @@
package sca_pkg;

  localparam int ENTRIES_DEF    = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_ADD       = 3'd1;
  localparam logic [2:0] ACT_READ      = 3'd2;
  localparam logic [2:0] ACT_CLR_VALS  = 3'd3;
  localparam logic [2:0] ACT_CLR_PROF  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // default quiet NaN for inf - inf
  localparam logic [63:0] DEF_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QNAN_BIT  = 64'h0008_0000_0000_0000;

endpackage

@@ rtl/sparse_coordinate_accumulator_core.sv @@
// Channel   Dir  Payload
// s_axis    in   tuser: action; tdata: row, col, value
// m_axis    out  tdata: entry_index, read_value, status
//
// One transaction at a time. Lookup scans the key memory one entry per cycle;
// add then passes through the align, normalize (one left shift per step), round
// and write-back states of the floating-point adder. Clear values sweeps the
// filled entries of the value memory; clear profile resets the fill count.
// rst empties the profile at once (fill count). A result waiting on m_axis
// holds the block in its final state until taken.
`include "sparse_coordinate_accumulator_core_defines.svh"

module sparse_coordinate_accumulator_core
  import sca_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // row[15:0], col[31:16], value[95:32]
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // entry_index[9:0], read_value[73:10], status[75:74]
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = 2 * COORD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_VRD   = 4'd2;
  localparam logic [3:0] S_ALIGN = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_ROUND = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]       state;
  logic [2:0]       act;
  logic [KEY_W-1:0] key;
  logic [63:0]      addv;
  logic [CNT_W-1:0] issue_k;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_k;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] entry_count;

  logic [9:0]  r_idx;
  logic [63:0] r_val;
  logic [1:0]  r_st;
  logic        out_valid;
  logic [9:0]  out_idx;
  logic [63:0] out_val;
  logic [1:0]  out_st;

  // adder datapath
  logic        f_sign;
  logic        f_sub;
  logic [11:0] f_exp;
  logic [55:0] f_mx;
  logic [55:0] f_my;
  logic [10:0] f_d;
  logic [55:0] f_m;

  // memories
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [63:0]      val_mem [ENTRIES];
  logic [KEY_W-1:0] key_q;
  logic [63:0]      val_q;
  logic             key_we;
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;
  logic [63:0]      val_wdata;
  logic [IDX_W-1:0] val_raddr;

  logic hit;
  logic scan_end;
  logic room;

  assign hit      = cmp_vld && (key_q == key);
  assign scan_end = !cmp_vld && (issue_k == entry_count);
  assign room     = entry_count < CNT_W'(ENTRIES);

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    val_waddr = slot;
    val_wdata = r_val;
    val_raddr = (state == S_SCAN) ? cmp_k : slot;
    unique case (state)
      S_SCAN: begin
        if (!hit && scan_end && act == ACT_INSERT && room) begin
          key_we    = 1'b1;
          val_we    = 1'b1;
          val_waddr = entry_count[IDX_W-1:0];
          val_wdata = 64'd0;
        end
      end
      S_WB: val_we = 1'b1;
      S_CLR: begin
        val_we    = 1'b1;
        val_waddr = issue_k[IDX_W-1:0];
        val_wdata = 64'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[entry_count[IDX_W-1:0]] <= key;
    key_q <= key_mem[issue_k[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_q <= val_mem[val_raddr];
  end

  // unpack: a is the stored value, b the addend
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [55:0] ma, mb;
  logic [10:0] ea_e, eb_e;

  always_comb begin
    ea    = val_q[62:52];
    eb    = addv[62:52];
    fa    = val_q[51:0];
    fb    = addv[51:0];
    a_nan = (ea == 11'h7FF) && (fa != 52'd0);
    b_nan = (eb == 11'h7FF) && (fb != 52'd0);
    a_inf = (ea == 11'h7FF) && (fa == 52'd0);
    b_inf = (eb == 11'h7FF) && (fb == 52'd0);
    ma    = {ea != 11'd0, fa, 3'b000};
    mb    = {eb != 11'd0, fb, 3'b000};
    ea_e  = (ea == 11'd0) ? 11'd1 : ea;
    eb_e  = (eb == 11'd0) ? 11'd1 : eb;
    a_big = val_q[62:0] >= addv[62:0];
  end

  // align and add
  logic [55:0] sh_y;
  logic        stk;
  logic [56:0] f_sum;

  always_comb begin
    if (f_d >= 11'd56) begin
      sh_y = 56'd0;
      stk  = |f_my;
    end else begin
      sh_y = f_my >> f_d[5:0];
      stk  = |(f_my & ((56'd1 << f_d[5:0]) - 56'd1));
    end
    if (f_sub) f_sum = {1'b0, f_mx} - {1'b0, sh_y[55:1], sh_y[0] | stk};
    else       f_sum = {1'b0, f_mx} + {1'b0, sh_y[55:1], sh_y[0] | stk};
  end

  // round to nearest even
  logic        rnd_up;
  logic [53:0] mr;
  logic [11:0] exp_f;
  logic [51:0] frac_f;
  logic [63:0] rnd_res;

  always_comb begin
    rnd_up = f_m[2] & (f_m[1] | f_m[0] | f_m[3]);
    mr     = {1'b0, f_m[55:3]} + 54'(rnd_up);
    if (mr[53]) begin
      exp_f  = f_exp + 12'd1;
      frac_f = 52'd0;
    end else begin
      exp_f  = mr[52] ? f_exp : 12'd0;
      frac_f = mr[51:0];
    end
    if (exp_f >= 12'd2047) rnd_res = {f_sign, 11'h7FF, 52'd0};
    else                   rnd_res = {f_sign, exp_f[10:0], frac_f};
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act     <= s_axis_tuser;
            key     <= {COORD_BITS'(s_axis_tdata[15:0]), COORD_BITS'(s_axis_tdata[31:16])};
            addv    <= s_axis_tdata[95:32];
            issue_k <= '0;
            cmp_vld <= 1'b0;
            r_idx   <= 10'd0;
            r_val   <= 64'd0;
            r_st    <= ST_OK;
            case (s_axis_tuser) inside
              ACT_INSERT, ACT_ADD, ACT_READ: state <= S_SCAN;
              ACT_CLR_VALS: state <= (entry_count != '0) ? S_CLR : S_DONE;
              ACT_CLR_PROF: begin
                entry_count <= '0;
                state       <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld <= issue_k < entry_count;
          cmp_k   <= issue_k[IDX_W-1:0];
          if (issue_k < entry_count) issue_k <= issue_k + CNT_W'(1);
          if (hit) begin
            slot  <= cmp_k;
            r_idx <= 10'(cmp_k);
            state <= S_VRD;
          end else if (scan_end) begin
            if (act == ACT_INSERT) begin
              if (room) begin
                r_idx       <= 10'(entry_count);
                entry_count <= entry_count + CNT_W'(1);
              end else begin
                r_st <= ST_FULL;
              end
            end else begin
              r_st <= ST_ABSENT;
            end
            state <= S_DONE;
          end
        end
        S_VRD: begin
          if (act != ACT_ADD) begin
            r_val <= val_q;
            state <= S_DONE;
          end else if (a_nan) begin
            r_val <= val_q | QNAN_BIT;
            state <= S_WB;
          end else if (b_nan) begin
            r_val <= addv | QNAN_BIT;
            state <= S_WB;
          end else if (a_inf && b_inf && (val_q[63] != addv[63])) begin
            r_val <= DEF_NAN;
            state <= S_WB;
          end else if (a_inf) begin
            r_val <= val_q;
            state <= S_WB;
          end else if (b_inf) begin
            r_val <= addv;
            state <= S_WB;
          end else begin
            f_sub <= val_q[63] != addv[63];
            if (a_big) begin
              f_sign <= val_q[63];
              f_exp  <= {1'b0, ea_e};
              f_mx   <= ma;
              f_my   <= mb;
              f_d    <= ea_e - eb_e;
            end else begin
              f_sign <= addv[63];
              f_exp  <= {1'b0, eb_e};
              f_mx   <= mb;
              f_my   <= ma;
              f_d    <= eb_e - ea_e;
            end
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (!f_sub && f_sum[56]) begin
            f_m   <= {f_sum[56:2], f_sum[1] | f_sum[0]};
            f_exp <= f_exp + 12'd1;
          end else begin
            f_m <= f_sum[55:0];
          end
          // exact cancellation gives +0
          if (f_sub && f_sum == 57'd0) f_sign <= 1'b0;
          state <= S_NORM;
        end
        S_NORM: begin
          if (!f_m[55] && f_exp > 12'd1 && f_m != 56'd0) begin
            f_m   <= {f_m[54:0], 1'b0};
            f_exp <= f_exp - 12'd1;
          end else begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          r_val <= rnd_res;
          state <= S_WB;
        end
        S_WB: state <= S_DONE;
        S_CLR: begin
          issue_k <= issue_k + CNT_W'(1);
          if (issue_k + CNT_W'(1) >= entry_count) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_idx   <= r_idx;
            out_val   <= r_val;
            out_st    <= r_st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_st, out_val, out_idx};

  `SCA_ASSERT_IMP(a_count_bound, 1'b1, entry_count <= CNT_W'(ENTRIES))
  `SCA_ASSERT_NXT(a_hold_done, state == S_DONE && out_valid && !m_axis_tready, state == S_DONE)
  `SCA_ASSERT_IMP(a_status_code, out_valid, out_st <= ST_FULL)
  `SCA_ASSERT_NXT(a_scan_leave, state == S_SCAN && hit, state == S_VRD)

endmodule
